[rtl/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("same");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("next");
`endif

[rtl/mcvc_pkg.sv]
package mcvc_pkg;
  localparam int CHANNELS = 16;
  localparam int CW = $clog2(CHANNELS);
  localparam logic [13:0] RATE_MAX = 14'h3FFF;
  localparam logic [15:0] UNITY = 16'h1000;

  localparam logic [3:0] K_ON = 4'd0, K_OFF = 4'd1, K_VOL = 4'd2, K_PAN = 4'd3,
                         K_BEND = 4'd5, K_CTL = 4'd7, K_MARK = 4'd8;
  localparam logic [1:0] A_NONE = 2'd0, A_KEYON = 2'd1, A_KEYOFF = 2'd2,
                         A_RETUNE = 2'd3;
  localparam logic [1:0] CFG_MASTER = 2'd0, CFG_COUNT = 2'd1, CFG_PERC = 2'd2,
                         CFG_PLAY = 2'd3;

  function automatic logic [13:0] semi(input logic [6:0] i);
    logic [13:0] t [0:59];
    t = '{14'h0200, 14'h021E, 14'h023F, 14'h0261, 14'h0285, 14'h02AB, 14'h02D4,
          14'h02FF, 14'h032D, 14'h035D, 14'h0390, 14'h03C7, 14'h0400, 14'h043D,
          14'h047D, 14'h04C2, 14'h050A, 14'h0557, 14'h05A8, 14'h05FE, 14'h0659,
          14'h06BA, 14'h0721, 14'h078D, 14'h0800, 14'h087A, 14'h08FB, 14'h0983,
          14'h0A14, 14'h0AAE, 14'h0B50, 14'h0BFD, 14'h0CB3, 14'h0D74, 14'h0E41,
          14'h0F1A, 14'h1000, 14'h10F4, 14'h11F6, 14'h1307, 14'h1429, 14'h155C,
          14'h16A1, 14'h17F9, 14'h1966, 14'h1AE9, 14'h1C82, 14'h1E34, 14'h2000,
          14'h21E7, 14'h23EB, 14'h260E, 14'h2851, 14'h2AB7, 14'h2D41, 14'h2FF2,
          14'h32CC, 14'h35D1, 14'h3904, 14'h3C68};
    if (i >= 7'd60) return RATE_MAX;
    return t[i[5:0]];
  endfunction
endpackage

[rtl/midi_channel_voice_controller.sv]
// channel   direction  handshake        word
// in_       input      valid / stall    one sequencer event
// out_      output     valid / stall    one voice command
// cfg_      input      valid / ready    register index + data
// Volume, pan, controller, marker, off and ignored events go from dispatch straight
// to output; a bend takes two multiplies, a note on a divide, a multiply, a divide
// and a multiply (percussion skips the last multiply, a bend ratio adds one more),
// all on the bit-serial divider and multiplier. Next event is taken the cycle after the result leaves.
// Reset is synchronous; all channel state returns to its reset values at once.
// in_stall is high while an event is in work or its result waits on out_stall.
module midi_channel_voice_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_kind,
  input  logic [7:0]  in_chan,
  input  logic [7:0]  in_data_one,
  input  logic [7:0]  in_data_two,
  input  logic [6:0]  in_base_note,
  input  logic [13:0] in_clip_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [3:0]  out_voice,
  output logic [7:0]  out_level,
  output logic [6:0]  out_balance,
  output logic [13:0] out_rate,
  output logic [15:0] out_marker,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mcvc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_DIV1, S_MUL2, S_DIV2, S_MUL3, S_MUL4, S_BENDM, S_RET, S_OUT
  } state_t;
  state_t state_r;

  logic [7:0]  master_r; logic [4:0] count_r; logic [15:0] perc_r; logic play_r;
  logic [7:0]  vol_r [CHANNELS]; logic [7:0] pan_r [CHANNELS];
  logic [7:0]  note_r [CHANNELS]; logic [CHANNELS-1:0] held_r;
  logic [13:0] nrate_r [CHANNELS]; logic [15:0] bend_r [CHANNELS];
  logic [15:0] marker_r;

  logic [3:0]  kind_r; logic [7:0] chan_r, d1_r, d2_r; logic [6:0] base_r;
  logic [13:0] clip_r, r_r;
  logic [1:0]  act_r; logic [7:0] lvl_r; logic [6:0] bal_r; logic [13:0] rate_o_r;
  logic        ov_r;

  logic        m_start, m_done, d_start, d_done;
  logic [15:0] m_a, m_b, d_n, d_q;
  logic [31:0] m_p;
  logic [CW-1:0] ci;
  logic        ok, perc;
  logic [13:0] clamped, lo, hi;
  logic [15:0] m_p12;
  logic [13:0] v14;
  logic [7:0]  tidx, sidx;
  logic [6:0]  tsel;

  mcvc_serial_mul u_mul (.clk, .rst_n, .start(m_start), .a(m_a), .b(m_b),
                         .done(m_done), .p(m_p));
  mcvc_div127 u_div (.clk, .rst_n, .start(d_start), .n(d_n), .done(d_done), .q(d_q));

  assign ci   = chan_r[CW-1:0];
  assign ok   = chan_r < 8'(CHANNELS);
  assign perc = (chan_r < 8'd16) && perc_r[chan_r[3:0]];
  assign m_p12 = (m_p[31:28] != 0) ? 16'hFFFF : m_p[27:12];
  assign clamped = (m_p12 == 16'd0) ? 14'd1 : (m_p12 > 16'(RATE_MAX)) ? RATE_MAX
                   : m_p12[13:0];
  // semitone index, clamped to 0..83
  always_comb begin
    logic signed [9:0] si;
    si = $signed({2'b0, d1_r}) - $signed({3'b0, base_r}) + 10'sd36;
    if (si < 0) tsel = 7'd0;
    else if (si > 10'sd83) tsel = 7'd83;
    else tsel = si[6:0];
  end
  assign v14 = {d2_r[6:0], d1_r[6:0]};
  assign tidx = 8'(v14[13:12]) + 8'd34;
  assign sidx = tidx + 8'd1;
  assign lo = semi(tidx[6:0]);
  assign hi = semi(sidx[6:0]);

  // second BENDM pass (kind tagged as marker) starts nothing
  assign m_start = (state_r == S_DIV1 && d_done) || (state_r == S_DIV2 && d_done)
                 || (state_r == S_BENDM && m_done && kind_r != K_MARK && !perc
                     && bend_r[ci] != UNITY)
                 || (state_r == S_DISP && kind_r == K_BEND)
                 || (state_r == S_MUL4 && m_done);
  always_comb begin
    m_a = '0; m_b = '0;
    case (state_r)
      S_DIV1:  begin m_a = d_q; m_b = 16'(master_r); end
      S_DIV2:  begin m_a = 16'(clip_r); m_b = 16'(semi(tsel)); end
      S_BENDM: begin m_a = 16'(clamped); m_b = bend_r[ci]; end
      S_DISP:  begin m_a = 16'(hi - lo); m_b = 16'(v14[11:0]); end
      S_MUL4:  begin m_a = 16'(nrate_r[ci]);
                     m_b = 16'(lo) + m_p[27:12]; if (m_b == 0) m_b = 16'd1; end
      default: ;
    endcase
  end
  assign d_start = (state_r == S_DISP && kind_r == K_ON) || (state_r == S_MUL2 && m_done);
  // level times master can pass 16 bits; any such value clamps to 128 anyway
  assign d_n = (state_r == S_DISP) ? 16'(vol_r[ci]) * 16'(d2_r)
             : (m_p[31:16] != 16'd0) ? 16'hFFFF : m_p[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0;
      master_r <= 8'd100; count_r <= 5'd16; perc_r <= '0; play_r <= 1'b0;
      held_r <= '0; marker_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        vol_r[i] <= 8'd100; pan_r[i] <= 8'd64; note_r[i] <= '0;
        nrate_r[i] <= '0; bend_r[i] <= UNITY;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MASTER: master_r <= cfg_data[7:0];
          CFG_COUNT:  count_r <= cfg_data[4:0];
          CFG_PERC:   perc_r <= cfg_data;
          CFG_PLAY:   play_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && !ov_r) begin
          kind_r <= in_kind; chan_r <= in_chan; d1_r <= in_data_one;
          d2_r <= in_data_two; base_r <= in_base_note; clip_r <= in_clip_rate;
          act_r <= A_NONE; lvl_r <= '0; bal_r <= '0; rate_o_r <= '0;
          state_r <= S_DISP;
        end
        S_DISP: begin
          if (kind_r == K_ON && play_r && ok && chan_r < 8'(count_r)) state_r <= S_DIV1;
          else if (kind_r == K_BEND && play_r && ok) state_r <= S_MUL4;
          else state_r <= S_OUT;
          case (kind_r)
            K_OFF: if (ok && held_r[ci] && note_r[ci] == d1_r) begin
              held_r[ci] <= 1'b0; act_r <= A_KEYOFF;
            end
            K_VOL: if (ok) vol_r[ci] <= d1_r;
            K_PAN: if (ok) pan_r[ci] <= d1_r;
            K_CTL: if (ok) begin
              if (d1_r == 8'd7) vol_r[ci] <= d2_r;
              else if (d1_r == 8'd10) pan_r[ci] <= d2_r;
            end
            K_MARK: marker_r <= {d2_r, d1_r};
            default: ;
          endcase
        end
        S_DIV1: if (d_done) state_r <= S_MUL2;
        S_MUL2: if (m_done) state_r <= S_DIV2;
        S_DIV2: if (d_done) begin
          lvl_r <= (d_q > 16'd128) ? 8'd128 : (d_q == 0) ? 8'd1 : d_q[7:0];
          state_r <= perc ? S_RET : S_MUL3;
          if (perc) begin
            r_r <= clip_r; nrate_r[ci] <= clip_r;
          end
        end
        S_MUL3: state_r <= S_BENDM;
        S_BENDM: if (m_done) begin
          r_r <= clamped;
          if (kind_r == K_MARK) state_r <= S_RET;
          else begin
            nrate_r[ci] <= clamped;
            if (!perc && bend_r[ci] != UNITY) begin
              kind_r <= K_MARK; state_r <= S_MUL3;
            end else state_r <= S_RET;
          end
        end
        S_MUL4: if (m_done) begin
          bend_r[ci] <= m_b; state_r <= S_RET;
        end
        S_RET: if (kind_r == K_BEND) begin
          if (m_done) begin
            if (held_r[ci] && !(chan_r < 8'(count_r) && perc)) begin
              act_r <= A_RETUNE; rate_o_r <= clamped;
            end
            state_r <= S_OUT;
          end
        end else begin
          note_r[ci] <= d1_r; held_r[ci] <= 1'b1; act_r <= A_KEYON;
          bal_r <= pan_r[ci][7] ? 7'd127 : pan_r[ci][6:0];
          rate_o_r <= r_r; state_r <= S_OUT;
        end
        S_OUT: if (!ov_r) begin
          ov_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
  // note: in the keyon path kind_r turns to marker only as an internal tag for
  // the second multiply; the marker write happened only in dispatch.

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_action = act_r;
  assign out_voice = (act_r != A_NONE) ? chan_r[3:0] : 4'd0;
  assign out_level = lvl_r;
  assign out_balance = bal_r;
  assign out_rate = rate_o_r;
  assign out_marker = marker_r;
  assign cfg_ready = 1'b1;
endmodule

[rtl/mcvc_serial_mul.sv]
// bit-serial multiply, one multiplier bit per cycle
module mcvc_serial_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic        done,
  output logic [31:0] p
);
  import mcvc_pkg::*;
  logic [31:0] acc_r, acc_nxt, a_r, a_nxt;
  logic [15:0] b_r, b_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r; a_nxt = a_r; b_nxt = b_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0; a_nxt = {16'd0, a}; b_nxt = b; cnt_nxt = 5'd16; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt = {a_r[30:0], 1'b0};
      b_nxt = {1'b0, b_r[15:1]};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt; a_r <= a_nxt; b_r <= b_nxt;
  end
  assign done = done_r;
  assign p = acc_r;
endmodule

[rtl/mcvc_div127.sv]
// bit-serial restoring divide by 127, one quotient bit per cycle
module mcvc_div127 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] n,
  output logic        done,
  output logic [15:0] q
);
  import mcvc_pkg::*;
  logic [15:0] n_r, n_nxt, q_r, q_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [8:0]  trial;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    n_nxt = n_r; q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, n_r[15]};
    if (start) begin
      n_nxt = n; q_nxt = '0; rem_nxt = '0; cnt_nxt = 5'd16; busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[14:0], 1'b0};
      if (trial >= 9'd127) begin
        rem_nxt = 8'(trial - 9'd127); q_nxt = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0]; q_nxt = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; q_r <= q_nxt; rem_r <= rem_nxt;
  end
  assign done = done_r;
  assign q = q_r;
endmodule

[rtl/mcvc_checker.sv]
`include "assert_macros.svh"
module mcvc_checker (
  input logic clk, input logic rst_n, input logic in_valid, input logic in_stall,
  input logic out_valid, input logic out_stall, input logic [1:0] out_action,
  input logic [3:0] out_voice, input logic [7:0] out_level
);
  `CHK_IMPL(p_busy, clk, rst_n, out_valid, in_stall)
  `CHK_NEXT(p_take, clk, rst_n, in_valid && !in_stall, in_stall)
  `CHK_NEXT(p_stay, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_level))
  `CHK_IMPL(p_lvl, clk, rst_n, out_valid && out_action != 2'd1, out_level == 8'd0)
  `CHK_IMPL(p_vc, clk, rst_n, out_valid && out_action == 2'd0, out_voice == 4'd0)
endmodule
bind midi_channel_voice_controller mcvc_checker u_chk (.clk, .rst_n, .in_valid,
  .in_stall, .out_valid, .out_stall, .out_action, .out_voice, .out_level);
